// ===== rtl/cbpg_pkg.sv =====
// Shared constants for the cubic Bezier point generator.
package cbpg_pkg;

  localparam int DEF_MAX_SEGMENTS = 63;
  localparam int DEF_COORD_WIDTH  = 16;

  // segment count / point index width
  localparam int SEG_W  = 6;
  // fraction bits of t, u and the Bernstein weights (t and u Q1.16, weights Q2.16)
  localparam int FRAC_W = 16;

endpackage

// ===== rtl/cbpg_req_if.sv =====
// Request channel: four control points and a segment count.
interface cbpg_req_if import cbpg_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) ();

  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] p0_x;
  logic signed [COORD_WIDTH-1:0] p0_y;
  logic signed [COORD_WIDTH-1:0] p1_x;
  logic signed [COORD_WIDTH-1:0] p1_y;
  logic signed [COORD_WIDTH-1:0] p2_x;
  logic signed [COORD_WIDTH-1:0] p2_y;
  logic signed [COORD_WIDTH-1:0] p3_x;
  logic signed [COORD_WIDTH-1:0] p3_y;
  logic        [SEG_W-1:0]       segment_count;

  modport source (
    output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, segment_count,
    input  ready
  );

  modport sink (
    input  valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, segment_count,
    output ready
  );

endinterface

// ===== rtl/cbpg_pt_if.sv =====
// Result channel: one curve point per transaction.
interface cbpg_pt_if import cbpg_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) ();

  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic        [SEG_W-1:0]       point_index;
  logic                          last_point;

  modport source (
    output valid, point_x, point_y, point_index, last_point,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, point_index, last_point,
    output ready
  );

endinterface

// ===== rtl/cubic_bezier_point_generator.sv =====
// Cubic Bezier point generator: sequencer around one shared multiplier and a serial divider.
//
// Usage:
//   in_ch  : one request transaction = control points P0..P3 (signed Q12.4 at
//            COORD_WIDTH bits) and segment_count n. n = 0 is taken as 1, and n
//            above MAX_SEGMENTS is saturated to MAX_SEGMENTS.
//   out_ch : n+1 point transactions, index 0..n, last_point set on index n.
//   in_ch.ready is high only while the block is idle; one request is worked
//   on at a time.
// Steps per point: the bit-serial divider (t = i*2^16/n, one quotient bit a
//   cycle), the multiply sequence (u prep, six weight products, eight
//   coordinate products, then draining the last product and the y sum),
//   then the output register, which holds the point until it is taken.
//   The next request is accepted the cycle after the last point's transaction.
// The serial divider and the single registered multiplier bound the speed:
//   every product goes through the multiplier, one per cycle.
// Reset (rst_n low, synchronous) returns the sequencer to idle; a request in
//   progress is dropped.
// Stall: while out_ch.ready is low the point is held in the output registers
//   and the sequencer waits; nothing is lost or repeated.
module cubic_bezier_point_generator import cbpg_pkg::*; #(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int COORD_WIDTH  = DEF_COORD_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  cbpg_req_if.sink  in_ch,
  cbpg_pt_if.source out_ch
);

  // Widths
  localparam int T_W    = FRAC_W + 1;            // t, u, uu, tt, b0, b3 (up to 1.0)
  localparam int WGT_W  = FRAC_W + 2;            // b1, b2 (up to 3.0 before truncation)
  localparam int AW     = WGT_W + 1;             // multiplier A, signed
  localparam int BW     = (COORD_WIDTH > WGT_W) ? COORD_WIDTH : WGT_W;
  localparam int PW     = AW + BW;               // product
  localparam int ACC_W  = PW + 2;                // sum of four products
  localparam int SH_W   = ACC_W - FRAC_W;        // sum after floor shift
  localparam int DIV_W  = SEG_W + FRAC_W;        // dividend i << 16
  localparam int REM_W  = SEG_W + 1;
  localparam int CTR_W  = 5;

  localparam logic [SEG_W-1:0] MAX_N  = SEG_W'(MAX_SEGMENTS);
  localparam logic [T_W-1:0]   ONE_Q  = T_W'(1) << FRAC_W;

  // Multiply sequence steps (value of ctr_r in ST_MUL)
  localparam logic [CTR_W-1:0] MS_PREP = CTR_W'(0);   // u = 1 - t
  localparam logic [CTR_W-1:0] MS_UU   = CTR_W'(1);   // u*u
  localparam logic [CTR_W-1:0] MS_TT   = CTR_W'(2);   // t*t
  localparam logic [CTR_W-1:0] MS_B0   = CTR_W'(3);   // uu*u
  localparam logic [CTR_W-1:0] MS_B3   = CTR_W'(4);   // tt*t
  localparam logic [CTR_W-1:0] MS_B1   = CTR_W'(5);   // uu*t, times 3 on writeback
  localparam logic [CTR_W-1:0] MS_B2   = CTR_W'(6);   // tt*u, times 3 on writeback
  localparam logic [CTR_W-1:0] MS_CX   = CTR_W'(7);   // b0..b3 * P0x..P3x
  localparam logic [CTR_W-1:0] MS_CY   = CTR_W'(11);  // b0..b3 * P0y..P3y
  localparam logic [CTR_W-1:0] MS_LAST = CTR_W'(14);  // last coordinate product
  localparam logic [CTR_W-1:0] MS_END  = CTR_W'(16);  // y sum complete
  localparam logic [CTR_W-1:0] DIV_END = CTR_W'(DIV_W - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CTR_W-1:0]          ctr_r;
  logic [CTR_W-1:0]          op_d_r;     // step whose product sits in prod_r
  logic [SEG_W-1:0]          idx_r;
  logic [SEG_W-1:0]          n_r;

  logic signed [COORD_WIDTH-1:0] ctrl_r [8];

  logic [REM_W-1:0]          rem_r;
  logic [DIV_W-1:0]          div_r;      // dividend out at the top, quotient in at the bottom

  logic [T_W-1:0]            u_r, uu_r, tt_r;
  logic [WGT_W-1:0]          b0_r, b1_r, b2_r, b3_r;
  logic signed [PW-1:0]      prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [COORD_WIDTH-1:0] px_r, py_r;

  logic in_acc, out_acc, is_last;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign is_last = (idx_r == n_r);

  // Segment count clean-up
  logic [SEG_W-1:0] seg_one, seg_eff;
  assign seg_one = (in_ch.segment_count == '0) ? SEG_W'(1) : in_ch.segment_count;
  assign seg_eff = (seg_one > MAX_N) ? MAX_N : seg_one;

  // Restoring divider step
  logic [REM_W-1:0] rem_sh, rem_nxt;
  logic             q_bit;
  assign rem_sh  = {rem_r[REM_W-2:0], div_r[DIV_W-1]};
  assign q_bit   = (rem_sh >= {1'b0, n_r});
  assign rem_nxt = q_bit ? (rem_sh - {1'b0, n_r}) : rem_sh;

  logic [T_W-1:0] t_val;
  assign t_val = div_r[T_W-1:0];

  // Multiplier operand select
  logic [CTR_W-1:0]          k_off;
  logic [2:0]                cidx;
  logic [WGT_W-1:0]          a_val;
  logic [WGT_W-1:0]          b_sel;
  logic signed [BW-1:0]      b_val;

  assign k_off = ctr_r - MS_CX;
  assign cidx  = {k_off[1:0], k_off[2]};

  always_comb begin
    case (k_off[1:0])
      2'd0:    b_sel = b0_r;
      2'd1:    b_sel = b1_r;
      2'd2:    b_sel = b2_r;
      default: b_sel = b3_r;
    endcase
  end

  always_comb begin
    case (ctr_r)
      MS_UU: begin
        a_val = WGT_W'(u_r);
        b_val = BW'(u_r);
      end
      MS_TT: begin
        a_val = WGT_W'(t_val);
        b_val = BW'(t_val);
      end
      MS_B0: begin
        a_val = WGT_W'(uu_r);
        b_val = BW'(u_r);
      end
      MS_B3: begin
        a_val = WGT_W'(tt_r);
        b_val = BW'(t_val);
      end
      MS_B1: begin
        a_val = WGT_W'(uu_r);
        b_val = BW'(t_val);
      end
      MS_B2: begin
        a_val = WGT_W'(tt_r);
        b_val = BW'(u_r);
      end
      default: begin
        a_val = b_sel;
        b_val = BW'(ctrl_r[cidx]);
      end
    endcase
  end

  // Writeback helpers
  logic [T_W-1:0]   prod_q;     // product >> 16 for weight steps
  logic [FRAC_W*2+1:0] prod_lo;
  logic [FRAC_W*2+2:0] prod_x3;
  logic [WGT_W-1:0] prod_q3;    // (3*product) >> 16

  assign prod_lo = prod_r[FRAC_W*2+1:0];
  assign prod_q  = prod_r[FRAC_W+T_W-1:FRAC_W];
  assign prod_x3 = {1'b0, prod_lo} + {prod_lo, 1'b0};
  assign prod_q3 = prod_x3[FRAC_W+WGT_W-1:FRAC_W];

  // Floor shift and saturation of the running sum
  logic signed [SH_W-1:0]        sh;
  logic [SH_W-COORD_WIDTH:0]     sh_hi;
  logic                          sh_ovf;
  logic signed [COORD_WIDTH-1:0] clamped;

  assign sh      = acc_r[ACC_W-1:FRAC_W];
  assign sh_hi   = sh[SH_W-1:COORD_WIDTH-1];
  assign sh_ovf  = !((&sh_hi) || !(|sh_hi));
  assign clamped = sh_ovf ? {sh[SH_W-1], {(COORD_WIDTH-1){~sh[SH_W-1]}}}
                          : sh[COORD_WIDTH-1:0];

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_DIV;
      ST_DIV:  if (ctr_r == DIV_END) state_nxt = ST_MUL;
      ST_MUL:  if (ctr_r == MS_END) state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_acc) state_nxt = is_last ? ST_IDLE : ST_DIV;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ctr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) ctr_r <= '0;
      else                      ctr_r <= ctr_r + CTR_W'(1);
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    op_d_r <= ctr_r;
    prod_r <= $signed({1'b0, a_val}) * b_val;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ctrl_r[0] <= in_ch.p0_x;
          ctrl_r[1] <= in_ch.p0_y;
          ctrl_r[2] <= in_ch.p1_x;
          ctrl_r[3] <= in_ch.p1_y;
          ctrl_r[4] <= in_ch.p2_x;
          ctrl_r[5] <= in_ch.p2_y;
          ctrl_r[6] <= in_ch.p3_x;
          ctrl_r[7] <= in_ch.p3_y;
          n_r       <= seg_eff;
          idx_r     <= '0;
          rem_r     <= '0;
          div_r     <= '0;
        end
      end
      ST_DIV: begin
        rem_r <= rem_nxt;
        div_r <= {div_r[DIV_W-2:0], q_bit};
      end
      ST_MUL: begin
        if (ctr_r == MS_PREP) u_r <= ONE_Q - t_val;
        if (ctr_r == MS_END)  py_r <= clamped;
        case (op_d_r)
          MS_UU: uu_r <= prod_q;
          MS_TT: tt_r <= prod_q;
          MS_B0: b0_r <= WGT_W'(prod_q);
          MS_B3: b3_r <= WGT_W'(prod_q);
          MS_B1: b1_r <= prod_q3;
          MS_B2: b2_r <= prod_q3;
          MS_CX: acc_r <= ACC_W'(prod_r);
          MS_CY: begin
            px_r  <= clamped;
            acc_r <= ACC_W'(prod_r);
          end
          default: begin
            if ((op_d_r > MS_CX && op_d_r < MS_CY) || (op_d_r > MS_CY && op_d_r <= MS_LAST))
              acc_r <= acc_r + ACC_W'(prod_r);
          end
        endcase
      end
      ST_OUT: begin
        if (out_acc && !is_last) begin
          idx_r <= idx_r + SEG_W'(1);
          rem_r <= '0;
          div_r <= {idx_r + SEG_W'(1), {FRAC_W{1'b0}}};
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = (state_r == ST_OUT);
  assign out_ch.point_x     = px_r;
  assign out_ch.point_y     = py_r;
  assign out_ch.point_index = idx_r;
  assign out_ch.last_point  = is_last;

  // Checks
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_DIV && idx_r == '0 && ctr_r == '0))
    else $error("request transaction did not start the divider at point 0");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (idx_r <= n_r))
    else $error("point index beyond segment count");

  a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (n_r != '0 && n_r <= MAX_N))
    else $error("active segment count out of range");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("request taken while a point is pending");

  a_next_point: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !is_last) |=> (state_r == ST_DIV && idx_r == $past(idx_r) + SEG_W'(1)))
    else $error("point index did not advance after a point transaction");

endmodule
